### design/qrnc_pkg.sv
// Shared constants and types for the quartic root nature classifier.
// Used by qrnc_mul and quartic_root_nature_classifier; depends on nothing.

package qrnc_pkg;

    // Default coefficient width.
    localparam int COEF_WIDTH = 16;

    // Operand slice width of the pipelined multiplier.
    localparam int MUL_CHUNK = 24;

    // Result class codes.
    localparam logic [1:0] CLS_FOUR_REAL = 2'd0;
    localparam logic [1:0] CLS_TWO_REAL  = 2'd1;
    localparam logic [1:0] CLS_NO_REAL   = 2'd2;
    localparam logic [1:0] CLS_UNDET     = 2'd3;

    // Sign facts gathered along the pipeline for the decision tree.
    typedef struct packed {
        logic a_zero;
        logic p_neg;
        logic p_pos;
        logic z_zero;
        logic d_neg;
        logic d_pos;
        logic r_zero;
    } sign_flags_t;

endpackage

### design/qrnc_mul.sv
// Three-stage signed multiplier built from MUL_CHUNK-bit slice products.
// Depends on qrnc_pkg.

module qrnc_mul #(
    parameter int AW = qrnc_pkg::COEF_WIDTH,
    parameter int BW = qrnc_pkg::COEF_WIDTH
) (
    input  logic                      clk,
    input  logic [2:0]                en,
    input  logic signed [AW-1:0]      a,
    input  logic signed [BW-1:0]      b,
    output logic signed [AW+BW-1:0]   p
);

    localparam int K   = qrnc_pkg::MUL_CHUNK;
    localparam int NA  = (AW + K - 1) / K;
    localparam int NB  = (BW + K - 1) / K;
    localparam int AXW = NA * K;
    localparam int BXW = NB * K;
    localparam int PW  = AW + BW;

    logic signed [AXW-1:0] a_ext;
    logic signed [BXW-1:0] b_ext;
    logic signed [K:0]     a_chunk [NA];
    logic signed [K:0]     b_chunk [NB];
    logic signed [2*K+1:0] pp_reg  [NA][NB];
    logic signed [PW-1:0]  row_next [NA];
    logic signed [PW-1:0]  row_reg  [NA];
    logic signed [PW-1:0]  sum_next;
    logic signed [PW-1:0]  p_reg;

    // Sign-extend both operands to whole slices.
    assign a_ext = AXW'(a);
    assign b_ext = BXW'(b);

    // Lower slices are unsigned, the top slice carries the sign.
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            a_chunk[i] = {((i == NA - 1) ? a_ext[AXW-1] : 1'b0), a_ext[i*K +: K]};
        end
        for (int j = 0; j < NB; j++)
        begin
            b_chunk[j] = {((j == NB - 1) ? b_ext[BXW-1] : 1'b0), b_ext[j*K +: K]};
        end
    end

    // Each row is one slice of a times all of b, kept modulo 2^PW.
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) <<< (K * (i + j)));
            end
        end
    end

    // Final sum of the rows; the true product always fits in PW bits.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + row_reg[i];
        end
    end

    // Slice products, row sums and result, one stage each.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_chunk[i] * b_chunk[j];
                end
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
        if (en[2])
        begin
            p_reg <= sum_next;
        end
    end

    assign p = p_reg;

endmodule

### design/quartic_root_nature_classifier.sv
// Sustains one item per cycle while the output is not stalled. The pipeline is a capture
// stage, three chained multiplier levels of three stages each, and the add, compare and
// decision stages around them. A stalled output backs the pipeline up stage by stage
// while empty stages keep filling. Reset clears only the stage valid bits; data
// registers are not reset. Depends on qrnc_pkg and qrnc_mul.

module quartic_root_nature_classifier #(
    parameter int COEF_WIDTH = qrnc_pkg::COEF_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          coef_valid,
    output logic                          coef_ready,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    input  logic signed [COEF_WIDTH-1:0]  coef_d,
    input  logic signed [COEF_WIDTH-1:0]  coef_e,
    output logic                          class_valid,
    input  logic                          class_ready,
    output logic [1:0]                    root_class
);

    localparam int CW    = COEF_WIDTH;
    localparam int SQW   = 2 * CW;          // product of two coefficients
    localparam int Z0W   = 2 * CW + 4;      // delta0 and P
    localparam int CUW   = 3 * CW;          // product of three coefficients
    localparam int RW    = 3 * CW + 3;      // R
    localparam int D1W   = 3 * CW + 6;      // delta1
    localparam int A2ZW  = SQW + Z0W;       // a^2 * delta0
    localparam int PPW   = 2 * Z0W;         // P^2 and delta0^2
    localparam int DPW   = 4 * CW + 6;      // 3*D
    localparam int CBW   = PPW + Z0W;       // delta0^3
    localparam int D1SQW = 2 * D1W;         // delta1^2
    localparam int DDW   = 6 * CW + 12;     // 27 * discriminant
    localparam int LAST  = 13;

    // Stage valid bits and per-stage advance enables.
    logic [LAST:0] v_reg;
    logic [LAST:0] en;

    // Coefficient delay lines, index equals stage.
    logic signed [CW-1:0] a_pipe_reg [5];
    logic signed [CW-1:0] b_pipe_reg [5];
    logic signed [CW-1:0] c_pipe_reg [5];
    logic signed [CW-1:0] d_pipe_reg [5];
    logic signed [CW-1:0] e_pipe_reg [5];

    // First multiplier level, valid at stage 3.
    logic signed [SQW-1:0] aa3, bb3, cc3, dd3, ac3, bd3, ae3, bc3;

    // Stage 4 registers.
    logic signed [SQW-1:0] aa4_reg, bb4_reg, cc4_reg, dd4_reg, ac4_reg, bc4_reg;
    logic signed [Z0W-1:0] z4_reg, z4_next;
    logic signed [Z0W-1:0] p4_reg, p4_next;

    // Second multiplier level, valid at stage 7.
    logic signed [CUW-1:0]  bbb7, aad7, acb7, ccc7, bcd7, bbe7, dda7, ace7;
    logic signed [A2ZW-1:0] a2z7;
    logic signed [PPW-1:0]  pp7, zz7;

    // delta0 carried from stage 5 to stage 8.
    logic signed [Z0W-1:0] zd_reg [4];

    // Stage 8 registers.
    logic signed [RW-1:0]  r8_reg, r8_next;
    logic signed [D1W-1:0] d18_reg, d18_next;
    logic signed [DPW-1:0] dp8_reg, dp8_next;
    logic signed [PPW-1:0] zz8_reg;

    // Third multiplier level, valid at stage 11.
    logic signed [CBW-1:0]   cube11;
    logic signed [D1SQW-1:0] d1sq11;

    // Stage 12 and 13 registers.
    logic signed [DDW-1:0] dd12_reg, dd12_next;
    logic [1:0]            cls_reg, cls_next;

    // Sign flags, index equals stage.
    qrnc_pkg::sign_flags_t flg_reg  [1:12];
    qrnc_pkg::sign_flags_t flg_next [1:12];

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || class_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= coef_valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign coef_ready  = en[0];
    assign class_valid = v_reg[LAST];
    assign root_class  = cls_reg;

    // Coefficient capture and delay up to stage 4.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_pipe_reg[0] <= coef_a;
            b_pipe_reg[0] <= coef_b;
            c_pipe_reg[0] <= coef_c;
            d_pipe_reg[0] <= coef_d;
            e_pipe_reg[0] <= coef_e;
        end
        for (int k = 1; k < 5; k++)
        begin
            if (en[k])
            begin
                a_pipe_reg[k] <= a_pipe_reg[k-1];
                b_pipe_reg[k] <= b_pipe_reg[k-1];
                c_pipe_reg[k] <= c_pipe_reg[k-1];
                d_pipe_reg[k] <= d_pipe_reg[k-1];
                e_pipe_reg[k] <= e_pipe_reg[k-1];
            end
        end
    end

    // First level: pairwise coefficient products.
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_aa
    (
        .clk(clk), .en(en[3:1]), .a(a_pipe_reg[0]), .b(a_pipe_reg[0]), .p(aa3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_bb
    (
        .clk(clk), .en(en[3:1]), .a(b_pipe_reg[0]), .b(b_pipe_reg[0]), .p(bb3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_cc
    (
        .clk(clk), .en(en[3:1]), .a(c_pipe_reg[0]), .b(c_pipe_reg[0]), .p(cc3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_dd
    (
        .clk(clk), .en(en[3:1]), .a(d_pipe_reg[0]), .b(d_pipe_reg[0]), .p(dd3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_ac
    (
        .clk(clk), .en(en[3:1]), .a(a_pipe_reg[0]), .b(c_pipe_reg[0]), .p(ac3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_bd
    (
        .clk(clk), .en(en[3:1]), .a(b_pipe_reg[0]), .b(d_pipe_reg[0]), .p(bd3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_ae
    (
        .clk(clk), .en(en[3:1]), .a(a_pipe_reg[0]), .b(e_pipe_reg[0]), .p(ae3)
    );
    qrnc_mul #(.AW(CW), .BW(CW)) u_mul_bc
    (
        .clk(clk), .en(en[3:1]), .a(b_pipe_reg[0]), .b(c_pipe_reg[0]), .p(bc3)
    );

    // delta0 = c^2 - 3bd + 12ae and P = 8ac - 3b^2.
    always_comb
    begin
        z4_next = Z0W'(cc3)
                - ((Z0W'(bd3) <<< 1) + Z0W'(bd3))
                + ((Z0W'(ae3) <<< 3) + (Z0W'(ae3) <<< 2));
        p4_next = (Z0W'(ac3) <<< 3) - ((Z0W'(bb3) <<< 1) + Z0W'(bb3));
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            aa4_reg <= aa3;
            bb4_reg <= bb3;
            cc4_reg <= cc3;
            dd4_reg <= dd3;
            ac4_reg <= ac3;
            bc4_reg <= bc3;
            z4_reg  <= z4_next;
            p4_reg  <= p4_next;
        end
    end

    // Second level: cubic terms, a^2 * delta0, P^2 and delta0^2.
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_bbb
    (
        .clk(clk), .en(en[7:5]), .a(bb4_reg), .b(b_pipe_reg[4]), .p(bbb7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_aad
    (
        .clk(clk), .en(en[7:5]), .a(aa4_reg), .b(d_pipe_reg[4]), .p(aad7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_acb
    (
        .clk(clk), .en(en[7:5]), .a(ac4_reg), .b(b_pipe_reg[4]), .p(acb7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_ccc
    (
        .clk(clk), .en(en[7:5]), .a(cc4_reg), .b(c_pipe_reg[4]), .p(ccc7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_bcd
    (
        .clk(clk), .en(en[7:5]), .a(bc4_reg), .b(d_pipe_reg[4]), .p(bcd7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_bbe
    (
        .clk(clk), .en(en[7:5]), .a(bb4_reg), .b(e_pipe_reg[4]), .p(bbe7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_dda
    (
        .clk(clk), .en(en[7:5]), .a(dd4_reg), .b(a_pipe_reg[4]), .p(dda7)
    );
    qrnc_mul #(.AW(SQW), .BW(CW)) u_mul_ace
    (
        .clk(clk), .en(en[7:5]), .a(ac4_reg), .b(e_pipe_reg[4]), .p(ace7)
    );
    qrnc_mul #(.AW(SQW), .BW(Z0W)) u_mul_a2z
    (
        .clk(clk), .en(en[7:5]), .a(aa4_reg), .b(z4_reg), .p(a2z7)
    );
    qrnc_mul #(.AW(Z0W), .BW(Z0W)) u_mul_pp
    (
        .clk(clk), .en(en[7:5]), .a(p4_reg), .b(p4_reg), .p(pp7)
    );
    qrnc_mul #(.AW(Z0W), .BW(Z0W)) u_mul_zz
    (
        .clk(clk), .en(en[7:5]), .a(z4_reg), .b(z4_reg), .p(zz7)
    );

    // Carry delta0 alongside the second level.
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            zd_reg[0] <= z4_reg;
        end
        for (int k = 1; k < 4; k++)
        begin
            if (en[k+5])
            begin
                zd_reg[k] <= zd_reg[k-1];
            end
        end
    end

    // R = b^3 + 8a^2d - 4abc,
    // delta1 = 2c^3 - 9bcd + 27b^2e + 27ad^2 - 72ace,
    // 3D = 16a^2 delta0 - P^2.
    always_comb
    begin
        r8_next = RW'(bbb7) + (RW'(aad7) <<< 3) - (RW'(acb7) <<< 2);
        d18_next = (D1W'(ccc7) <<< 1)
                 - ((D1W'(bcd7) <<< 3) + D1W'(bcd7))
                 + ((D1W'(bbe7) <<< 5) - (D1W'(bbe7) <<< 2) - D1W'(bbe7))
                 + ((D1W'(dda7) <<< 5) - (D1W'(dda7) <<< 2) - D1W'(dda7))
                 - ((D1W'(ace7) <<< 6) + (D1W'(ace7) <<< 3));
        dp8_next = (DPW'(a2z7) <<< 4) - DPW'(pp7);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            r8_reg  <= r8_next;
            d18_reg <= d18_next;
            dp8_reg <= dp8_next;
            zz8_reg <= zz7;
        end
    end

    // Third level: delta0^3 and delta1^2.
    qrnc_mul #(.AW(PPW), .BW(Z0W)) u_mul_cube
    (
        .clk(clk), .en(en[11:9]), .a(zz8_reg), .b(zd_reg[3]), .p(cube11)
    );
    qrnc_mul #(.AW(D1W), .BW(D1W)) u_mul_d1sq
    (
        .clk(clk), .en(en[11:9]), .a(d18_reg), .b(d18_reg), .p(d1sq11)
    );

    // 27 times the discriminant: 4 delta0^3 - delta1^2.
    assign dd12_next = (DDW'(cube11) <<< 2) - DDW'(d1sq11);

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            dd12_reg <= dd12_next;
        end
    end

    // Sign flags are filled in as their values become available.
    always_comb
    begin
        flg_next[1]        = '0;
        flg_next[1].a_zero = (a_pipe_reg[0] == '0);
        for (int k = 2; k <= 12; k++)
        begin
            flg_next[k] = flg_reg[k-1];
        end
        flg_next[5].p_neg  = p4_reg[Z0W-1];
        flg_next[5].p_pos  = !p4_reg[Z0W-1] && (p4_reg != '0);
        flg_next[5].z_zero = (z4_reg == '0);
        flg_next[9].d_neg  = dp8_reg[DPW-1];
        flg_next[9].d_pos  = !dp8_reg[DPW-1] && (dp8_reg != '0);
        flg_next[9].r_zero = (r8_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= 12; k++)
        begin
            if (en[k])
            begin
                flg_reg[k] <= flg_next[k];
            end
        end
    end

    // Decision tree on the signs.
    always_comb
    begin
        logic disc_neg;
        logic disc_zero;
        logic d_zero;
        qrnc_pkg::sign_flags_t f;

        f         = flg_reg[12];
        disc_neg  = dd12_reg[DDW-1];
        disc_zero = (dd12_reg == '0);
        d_zero    = !f.d_neg && !f.d_pos;

        if (f.a_zero)
        begin
            // Not a quartic.
            cls_next = qrnc_pkg::CLS_UNDET;
        end
        else if (disc_neg)
        begin
            cls_next = qrnc_pkg::CLS_TWO_REAL;
        end
        else if (!disc_zero)
        begin
            cls_next = (f.p_neg && f.d_neg) ? qrnc_pkg::CLS_FOUR_REAL
                                            : qrnc_pkg::CLS_NO_REAL;
        end
        else if (f.p_neg && f.d_neg && !f.z_zero)
        begin
            cls_next = qrnc_pkg::CLS_FOUR_REAL;
        end
        else if (f.d_pos || (f.p_pos && (!d_zero || !f.r_zero)))
        begin
            cls_next = qrnc_pkg::CLS_TWO_REAL;
        end
        else if (f.z_zero && !d_zero)
        begin
            cls_next = qrnc_pkg::CLS_FOUR_REAL;
        end
        else if (d_zero && f.p_neg)
        begin
            // Two real double roots.
            cls_next = qrnc_pkg::CLS_FOUR_REAL;
        end
        else if (d_zero && f.p_pos && f.r_zero)
        begin
            // Complex double roots.
            cls_next = qrnc_pkg::CLS_NO_REAL;
        end
        else if (d_zero && f.z_zero)
        begin
            cls_next = qrnc_pkg::CLS_FOUR_REAL;
        end
        else
        begin
            cls_next = qrnc_pkg::CLS_UNDET;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

### tb/testbench.sv
// Self-checking testbench for the quartic root nature classifier.
// Drives coefficient items, predicts each root class exactly and checks it.
// Depends on qrnc_pkg and quartic_root_nature_classifier.
`timescale 1ns / 100ps

module testbench;

    localparam int CW = qrnc_pkg::COEF_WIDTH;
    localparam int LATENCY = 13;
    localparam int DRAIN_CYCLES = 4 * LATENCY;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [CW-1:0] coef_t;
    // Degree-six products of 16-bit values with the largest weight stay well below 2^110.
    typedef logic signed [127:0] wide_t;

    typedef struct {
        coef_t      a;
        coef_t      b;
        coef_t      c;
        coef_t      d;
        coef_t      e;
        logic [1:0] root_class;
    } pending_class_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       coef_valid = 1'b0;
    logic       coef_ready;
    coef_t      coef_a = '0;
    coef_t      coef_b = '0;
    coef_t      coef_c = '0;
    coef_t      coef_d = '0;
    coef_t      coef_e = '0;
    logic       class_valid;
    logic       class_ready = 1'b0;
    logic [1:0] root_class;

    pending_class_t pending_classes[$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    bit             idle_on = 1'b1;
    int             factored [0:4];

    quartic_root_nature_classifier uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef_valid  (coef_valid),
        .coef_ready  (coef_ready),
        .coef_a      (coef_a),
        .coef_b      (coef_b),
        .coef_c      (coef_c),
        .coef_d      (coef_d),
        .coef_e      (coef_e),
        .class_valid (class_valid),
        .class_ready (class_ready),
        .root_class  (root_class)
    );

    always #10 clk = ~clk;

    // Run limit: ends the simulation as failed once cycle_count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int sign_of(wide_t v);
        if (v < 0)
            return -1;
        else if (v == 0)
            return 0;
        return 1;
    endfunction

    // Exact root class of a*x^4 + b*x^3 + c*x^2 + d*x + e from the sign tree.
    function automatic logic [1:0] classify_roots(coef_t ca, coef_t cb, coef_t cc,
                                                  coef_t cd, coef_t ce);
        wide_t a, b, c, d, e;
        wide_t disc, p_val, d_val, delta0, r_val;
        int    s_disc, s_p, s_d, s_z, s_r;
        a = ca;
        b = cb;
        c = cc;
        d = cd;
        e = ce;
        disc = 256 * a*a*a * e*e*e
             - 192 * a*a * b * d * e*e
             - 128 * a*a * c*c * e*e
             + 144 * a*a * c * d*d * e
             - 27 * a*a * d*d*d*d
             + 144 * a * b*b * c * e*e
             - 6 * a * b*b * d*d * e
             - 80 * a * b * c*c * d * e
             + 18 * a * b * c * d*d*d
             + 16 * a * c*c*c*c * e
             - 4 * a * c*c*c * d*d
             - 27 * b*b*b*b * e*e
             + 18 * b*b*b * c * d * e
             - 4 * b*b*b * d*d*d
             - 4 * b*b * c*c*c * e
             + b*b * c*c * d*d;
        p_val  = 8 * a * c - 3 * b*b;
        delta0 = c*c - 3 * b * d + 12 * a * e;
        d_val  = 64 * a*a*a * e - 16 * a*a * c*c + 16 * a * b*b * c
               - 16 * a*a * b * d - 3 * b*b*b*b;
        r_val  = b*b*b + 8 * a*a * d - 4 * a * b * c;
        s_disc = sign_of(disc);
        s_p    = sign_of(p_val);
        s_d    = sign_of(d_val);
        s_z    = sign_of(delta0);
        s_r    = sign_of(r_val);

        if (a == 0)
            return qrnc_pkg::CLS_UNDET;
        if (s_disc < 0)
            return qrnc_pkg::CLS_TWO_REAL;
        if (s_disc > 0)
            return (s_p < 0 && s_d < 0) ? qrnc_pkg::CLS_FOUR_REAL : qrnc_pkg::CLS_NO_REAL;
        // Zero discriminant: at least one repeated root.
        if (s_p < 0 && s_d < 0 && s_z != 0)
            return qrnc_pkg::CLS_FOUR_REAL;
        if (s_d > 0 || (s_p > 0 && (s_d != 0 || s_r != 0)))
            return qrnc_pkg::CLS_TWO_REAL;
        if (s_z == 0 && s_d != 0)
            return qrnc_pkg::CLS_FOUR_REAL;
        if (s_d == 0 && s_p < 0)
            return qrnc_pkg::CLS_FOUR_REAL;
        if (s_d == 0 && s_p > 0 && s_r == 0)
            return qrnc_pkg::CLS_NO_REAL;
        if (s_d == 0 && s_z == 0)
            return qrnc_pkg::CLS_FOUR_REAL;
        return qrnc_pkg::CLS_UNDET;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Sends one coefficient item, with an optional idle burst first, and records
    // its expected class once it is accepted.
    task automatic send_coefs(input int a, input int b, input int c, input int d,
                              input int e);
        pending_class_t item;
        int             gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            coef_valid <= 1'b0;
            coef_a <= coef_t'($urandom());
            coef_e <= coef_t'($urandom());
            repeat (gap) @(posedge clk);
        end
        item.a = coef_t'(a);
        item.b = coef_t'(b);
        item.c = coef_t'(c);
        item.d = coef_t'(d);
        item.e = coef_t'(e);
        item.root_class = classify_roots(item.a, item.b, item.c, item.d, item.e);
        coef_valid <= 1'b1;
        coef_a <= item.a;
        coef_b <= item.b;
        coef_c <= item.c;
        coef_d <= item.d;
        coef_e <= item.e;
        @(posedge clk);
        while (!coef_ready)
            @(posedge clk);
        pending_classes.push_back(item);
    endtask

    // Holds the sender off until every expected class has been checked.
    task automatic wait_drained();
        coef_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_classes.size() != 0);
    endtask

    // Result checker: compares each accepted class with the oldest expectation.
    always @(posedge clk)
    begin
        pending_class_t want;
        if (rst_n && class_valid && class_ready)
        begin
            if (pending_classes.size() == 0)
                report_mismatch($sformatf("class %0d with no item pending", root_class));
            else
            begin
                want = pending_classes.pop_front();
                if (root_class !== want.root_class)
                    report_mismatch($sformatf("coefs %0d %0d %0d %0d %0d: class %0d, want %0d",
                        want.a, want.b, want.c, want.d, want.e, root_class,
                        want.root_class));
            end
        end
    end

    // Receiver: ready drops in random bursts while idling is enabled.
    always
    begin
        @(posedge clk);
        if (rst_n && idle_on && $urandom_range(0, 4) == 0)
        begin
            class_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
            class_ready <= 1'b1;
        end
        else
            class_ready <= 1'b1;
    end

    // Mostly small or full-range values, with the field extremes mixed in.
    function automatic int pick_coef();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return -32768;
            4: return 32767;
            5: return int'($urandom_range(0, 64)) - 32;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Multiplies the working polynomial by c2*x^2 + c1*x + c0.
    task automatic multiply_factor(input int c2, input int c1, input int c0);
        int prev [0:4];
        int k;
        prev = factored;
        for (k = 0; k < 5; k++)
            factored[k] = c0 * prev[k] + (k >= 1 ? c1 * prev[k-1] : 0)
                        + (k >= 2 ? c2 * prev[k-2] : 0);
    endtask

    // Builds a scaled product of linear factors with small integer roots and quadratic
    // factors with small coefficients, so repeated roots and zero discriminants come up often.
    task automatic send_factored();
        int scale, mode, shared_root, p, q, k;
        scale = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1)
            scale = -scale;
        for (k = 0; k < 5; k++)
            factored[k] = 0;
        factored[0] = scale;
        mode = $urandom_range(0, 2);
        shared_root = int'($urandom_range(0, 10)) - 5;
        repeat (4 - 2 * mode)
        begin
            if ($urandom_range(0, 1) == 1)
                multiply_factor(0, 1, -shared_root);
            else
                multiply_factor(0, 1, 5 - int'($urandom_range(0, 10)));
        end
        p = int'($urandom_range(0, 12)) - 6;
        q = int'($urandom_range(0, 12)) - 6;
        repeat (mode)
        begin
            multiply_factor(1, p, q);
            // A squared quadratic is kept a third of the time.
            if ($urandom_range(0, 2) != 0)
            begin
                p = int'($urandom_range(0, 12)) - 6;
                q = int'($urandom_range(0, 12)) - 6;
            end
        end
        // A few broken sets: one coefficient nudged off the exact product.
        if ($urandom_range(0, 7) == 0)
        begin
            k = $urandom_range(0, 4);
            factored[k] = factored[k] + ($urandom_range(0, 1) == 1 ? 1 : -1);
        end
        send_coefs(factored[4], factored[3], factored[2], factored[1], factored[0]);
    endtask

    task automatic test_degenerate_leading();
        send_coefs(0, 0, 0, 0, 0);
        send_coefs(0, 32767, -32768, 1, -1);
        send_coefs(0, 1, -3, 3, -1);
    endtask

    task automatic test_field_extremes();
        send_coefs(-32768, -32768, -32768, -32768, -32768);
        send_coefs(32767, 32767, 32767, 32767, 32767);
        send_coefs(-32768, 32767, -32768, 32767, -32768);
        send_coefs(32767, -32768, 32767, -32768, 32767);
        send_coefs(1, 0, 0, 0, 0);
        send_coefs(1, 0, 0, 0, 1);
        send_coefs(-1, 0, 0, 0, 1);
        send_coefs(32767, 0, -32768, 0, 32767);
    endtask

    task automatic test_zero_discriminant();
        // Quadruple root.
        send_coefs(1, -4, 6, -4, 1);
        // Triple root plus a simple one.
        send_coefs(1, -2, 0, 2, -1);
        // Two real double roots.
        send_coefs(1, 0, -2, 0, 1);
        // Complex double roots.
        send_coefs(1, 0, 2, 0, 1);
        // Real double root and a complex pair.
        send_coefs(1, -2, 2, -2, 1);
        // Real double root and two simple real roots.
        send_coefs(1, -7, 17, -17, 6);
        // Same with a negative scale.
        send_coefs(-3, 21, -51, 51, -18);
    endtask

    task automatic test_nonzero_discriminant();
        send_coefs(1, -10, 35, -50, 24);
        send_coefs(1, 0, 5, 0, 4);
        send_coefs(1, -3, 3, -3, 2);
        send_coefs(-2, 6, -6, 6, -4);
    endtask

    task automatic test_uniform_random();
        repeat (400)
            send_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
    endtask

    task automatic test_factored_random();
        repeat (500)
        begin
            // Roughly one item in ten is unstructured noise.
            if ($urandom_range(0, 9) == 0)
                send_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
            else
                send_factored();
        end
    endtask

    task automatic test_sender_pause();
        repeat (3)
        begin
            repeat (30) send_factored();
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (100)
        begin
            if ($urandom_range(0, 1) == 1)
                send_factored();
            else
                send_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_leading();
        test_field_extremes();
        test_zero_discriminant();
        test_nonzero_discriminant();
        test_uniform_random();
        test_factored_random();
        test_sender_pause();
        test_back_to_back();

        // Let the pipeline empty, then watch for stray results.
        coef_valid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_classes.size() != 0)
            report_mismatch($sformatf("%0d items never produced a class",
                pending_classes.size()));

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
